// ===== rtl/mssg_pkg.sv =====
// Package for the multitone / sweep sine generator.
// Register map, field widths, default values and fixed arithmetic constants.
// No dependencies.
package mssg_pkg;

	// default build values
	localparam int DEF_TONES           = 4;
	localparam int DEF_TABLE_ADDR_BITS = 10;
	localparam int DEF_PHASE_BITS      = 32;

	// field widths
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CNT_W       = 3;
	localparam int STEP_W      = 32;
	localparam int RATIO_W     = 32;
	localparam int RATIO_FRAC  = 30;
	localparam int AMP_W       = 15;
	localparam int SAMPLE_W    = 16;
	localparam int STEP_REGS   = 4;
	localparam int STEP_IDX_W  = 2;

	// summed table values: up to four of +/-32767
	localparam int ACC_W       = 18;
	localparam int SCALED_W    = ACC_W + AMP_W + 1;
	localparam int MAG_W       = SCALED_W - 1;

	// sine table build, Q30
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int          FULL_SCALE  = 32767;

	// floor(a/3) = (a * 43691) >> 17 for a < 2^15
	localparam int DIV3_RECIP = 43691;
	localparam int DIV3_SHIFT = 17;
	localparam int DIV3_W     = AMP_W + 16;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int FIFO_CW    = FIFO_AW + 1;

	// reset values
	localparam logic [CNT_W-1:0]   TONE_COUNT_RST  = 3'd1;
	localparam logic [RATIO_W-1:0] SWEEP_RATIO_RST = 32'd1073741824;
	localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 15'd32000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SWEEP_MODE  = 3'd0,
		REG_TONE_COUNT  = 3'd1,
		REG_TONE0_STEP  = 3'd2,
		REG_TONE1_STEP  = 3'd3,
		REG_TONE2_STEP  = 3'd4,
		REG_TONE3_STEP  = 3'd5,
		REG_SWEEP_RATIO = 3'd6,
		REG_AMPLITUDE   = 3'd7
	} cfg_reg_t;

endpackage

// ===== rtl/multitone_sweep_sine_generator.sv =====
// Multitone / exponential-sweep sine generator, phase-accumulator based.
// Phase store, quarter-wave sine ROM, scaling and an 8-word result queue.
// Depends on mssg_pkg.
//
//  channel   handshake                 word
//  input     in_valid / in_stall       restart
//  output    out_valid / out_stall     sample
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Each word holds the phase store and the sine ROM for each of its tone slots in turn,
// one tone a cycle; a new word is taken in the cycle the last tone issues.
// A word passes the issue sequencer and stages 1 to 5 before it enters the output
// queue, and can leave it in the cycle after it enters.
// Reset sets registers to their defaults and all phases and the sweep step to zero.
// The queue holds 8 words; input stalls once 8 words are accepted and not yet taken.
module multitone_sweep_sine_generator #(
	parameter int TONES           = mssg_pkg::DEF_TONES,
	parameter int TABLE_ADDR_BITS = mssg_pkg::DEF_TABLE_ADDR_BITS,
	parameter int PHASE_BITS      = mssg_pkg::DEF_PHASE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             restart,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [mssg_pkg::SAMPLE_W-1:0] sample,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mssg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mssg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mssg_pkg::*;

	localparam int LIVE      = (TONES < STEP_REGS) ? TONES : STEP_REGS;
	localparam int SLOT_W    = (LIVE > 1) ? $clog2(LIVE) : 1;
	localparam int QSIZE     = 1 << TABLE_ADDR_BITS;
	localparam int ROM_DEPTH = QSIZE + 1;
	localparam int ROM_AW    = TABLE_ADDR_BITS + 1;
	localparam int PROD_W    = PHASE_BITS + RATIO_W;
	localparam int SH_W      = PROD_W - RATIO_FRAC;
	localparam logic [PHASE_BITS-1:0] PHALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

	function automatic logic [AMP_W-1:0] sine_entry(input int unsigned i);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x  = (HALF_PI_Q30 * 64'(i)) >> TABLE_ADDR_BITS;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		s  = (s * 64'(FULL_SCALE) + (ONE_Q30 >> 1)) >> 30;
		if (s > 64'(FULL_SCALE))
			s = 64'(FULL_SCALE);
		return AMP_W'(s);
	endfunction

	// configuration
	logic                  sweep_mode_q;
	logic [CNT_W-1:0]      tone_count_q;
	logic [STEP_W-1:0]     tone_step_q [STEP_REGS];
	logic [RATIO_W-1:0]    sweep_ratio_q;
	logic [AMP_W-1:0]      amplitude_q;
	logic [AMP_W-1:0]      scale_q;
	logic [CNT_W-1:0]      count_eff;
	logic [DIV3_W-1:0]     div3_prod;

	// issue
	logic                  issue_v_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  restart_q;
	logic                  issue_last;
	logic                  accept;
	logic [PHASE_BITS-1:0] sweep_step_q;
	logic [PHASE_BITS-1:0] step0_m;
	logic [PHASE_BITS-1:0] step0_cl;
	logic [PHASE_BITS-1:0] cur_step;
	logic [PHASE_BITS-1:0] eff_step;

	// phase store
	logic [PHASE_BITS-1:0] phase_mem [LIVE];
	logic [LIVE-1:0]       phase_ok_q;

	// stage 1
	logic                  v_s1, first_s1, last_s1, restart_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic [PHASE_BITS-1:0] rd_s1;
	logic [PHASE_BITS-1:0] step_s1;
	logic [PROD_W-1:0]     prod_s1;
	logic [SH_W-1:0]       prod_sh;
	logic [PHASE_BITS-1:0] next_step;
	logic [PHASE_BITS-1:0] eff_phase;
	logic [PHASE_BITS-1:0] add_step;
	logic [PHASE_BITS-1:0] wdata;
	logic [STEP_IDX_W-1:0] step_idx;
	logic                  incl;
	logic [TABLE_ADDR_BITS-1:0] idx;
	logic [ROM_AW-1:0]     rom_addr;
	logic [AMP_W-1:0]      sine_rom [ROM_DEPTH];

	// stage 2
	logic                  v_s2, first_s2, last_s2, neg_s2, inc_s2;
	logic [AMP_W-1:0]      rom_s2;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] total;
	logic signed [ACC_W-1:0] acc_q;

	// stages 3 to 5
	logic                    v_s3, v_s4, v_s5, neg_s5;
	logic signed [ACC_W-1:0] acc_s3;
	logic signed [SCALED_W-1:0] prod_s4;
	logic [MAG_W-1:0]        mag_s5;
	logic [MAG_W-16:0]       q1;
	logic [MAG_W-15:0]       r1;
	logic [MAG_W-30:0]       q2;
	logic [SAMPLE_W-1:0]     r2;
	logic [MAG_W-14:0]       qt;
	logic [AMP_W-1:0]        qs;
	logic [SAMPLE_W-1:0]     res;

	// result queue
	logic [SAMPLE_W-1:0]  fifo_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0]   fill_q, credit_q;
	logic                 pop;

	for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
		localparam logic [AMP_W-1:0] ENTRY = sine_entry(g);
		assign sine_rom[g] = ENTRY;
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_mode_q  <= 1'b0;
			tone_count_q  <= TONE_COUNT_RST;
			sweep_ratio_q <= SWEEP_RATIO_RST;
			amplitude_q   <= AMPLITUDE_RST;
			for (int i = 0; i < STEP_REGS; i++)
				tone_step_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SWEEP_MODE:  sweep_mode_q   <= cfg_data[0];
				REG_TONE_COUNT:  tone_count_q   <= cfg_data[CNT_W-1:0];
				REG_TONE0_STEP:  tone_step_q[0] <= cfg_data;
				REG_TONE1_STEP:  tone_step_q[1] <= cfg_data;
				REG_TONE2_STEP:  tone_step_q[2] <= cfg_data;
				REG_TONE3_STEP:  tone_step_q[3] <= cfg_data;
				REG_SWEEP_RATIO: sweep_ratio_q  <= cfg_data;
				REG_AMPLITUDE:   amplitude_q    <= cfg_data[AMP_W-1:0];
			endcase
		end
	end

	always_comb begin
		priority if (tone_count_q == '0)
			count_eff = CNT_W'(1);
		else if (tone_count_q > CNT_W'(LIVE))
			count_eff = CNT_W'(LIVE);
		else
			count_eff = tone_count_q;
	end

	assign div3_prod = DIV3_W'(amplitude_q) * DIV3_W'(DIV3_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= AMPLITUDE_RST;
		end else if (sweep_mode_q) begin
			scale_q <= amplitude_q;
		end else begin
			unique case (count_eff)
				3'd2:    scale_q <= amplitude_q >> 1;
				3'd3:    scale_q <= AMP_W'(div3_prod >> DIV3_SHIFT);
				3'd4:    scale_q <= amplitude_q >> 2;
				default: scale_q <= amplitude_q;
			endcase
		end
	end

	// issue sequencer: one tone slot a cycle
	assign issue_last = (slot_q == SLOT_W'(LIVE - 1));
	assign in_stall   = (issue_v_q && !issue_last) || (credit_q == FIFO_CW'(FIFO_DEPTH));
	assign accept     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_v_q <= 1'b0;
			slot_q    <= '0;
			restart_q <= 1'b0;
		end else if (accept) begin
			issue_v_q <= 1'b1;
			slot_q    <= '0;
			restart_q <= restart;
		end else if (issue_v_q) begin
			if (issue_last)
				issue_v_q <= 1'b0;
			else
				slot_q <= slot_q + SLOT_W'(1);
		end
	end

	// sweep step, forwarded from stage 1 when it is just being updated
	assign step0_m  = tone_step_q[0][PHASE_BITS-1:0];
	assign step0_cl = (step0_m > PHALF) ? PHALF : step0_m;
	assign prod_sh  = prod_s1[PROD_W-1:RATIO_FRAC];
	assign next_step = !sweep_mode_q ? step_s1 :
		(prod_sh > SH_W'(PHALF)) ? PHALF : prod_sh[PHASE_BITS-1:0];
	assign cur_step = (v_s1 && first_s1) ? next_step : sweep_step_q;
	assign eff_step = restart_q ? step0_cl : cur_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sweep_step_q <= '0;
		else if (v_s1 && first_s1)
			sweep_step_q <= next_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue_v_q;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1    <= slot_q;
		first_s1   <= (slot_q == '0);
		last_s1    <= issue_last;
		restart_s1 <= restart_q;
		step_s1    <= eff_step;
		prod_s1    <= PROD_W'(eff_step) * PROD_W'(sweep_ratio_q);
		if (v_s1 && slot_s1 == slot_q)
			rd_s1 <= wdata;
		else if (phase_ok_q[slot_q])
			rd_s1 <= phase_mem[slot_q];
		else
			rd_s1 <= '0;
	end

	// stage 1: phase update and table address
	assign step_idx  = STEP_IDX_W'(slot_s1);
	assign eff_phase = restart_s1 ? '0 : rd_s1;
	assign add_step  = sweep_mode_q ? (first_s1 ? step_s1 : '0)
		: tone_step_q[step_idx][PHASE_BITS-1:0];
	assign wdata     = eff_phase + add_step;
	assign incl      = sweep_mode_q ? first_s1 : (CNT_W'(slot_s1) < count_eff);
	assign idx       = eff_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
	assign rom_addr  = eff_phase[PHASE_BITS-2] ? (ROM_AW'(QSIZE) - {1'b0, idx}) : {1'b0, idx};

	always_ff @(posedge clk) begin
		if (v_s1)
			phase_mem[slot_s1] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_ok_q <= '0;
		else if (v_s1)
			phase_ok_q[slot_s1] <= 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		rom_s2   <= sine_rom[rom_addr];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		neg_s2   <= eff_phase[PHASE_BITS-1];
		inc_s2   <= incl;
	end

	// stage 2: sum the tones of one word
	always_comb begin
		term = '0;
		if (inc_s2)
			term = neg_s2 ? -$signed(ACC_W'(rom_s2)) : $signed(ACC_W'(rom_s2));
	end

	assign total = (first_s2 ? '0 : acc_q) + term;

	always_ff @(posedge clk) begin
		if (v_s2)
			acc_q <= total;
		if (v_s2 && last_s2)
			acc_s3 <= total;
		prod_s4 <= SCALED_W'(acc_s3) * $signed({1'b0, scale_q});
		neg_s5  <= prod_s4[SCALED_W-1];
		mag_s5  <= prod_s4[SCALED_W-1] ? MAG_W'(-prod_s4) : MAG_W'(prod_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s3 <= v_s2 && last_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 5: divide by 32767, toward zero, via 2^15 folding
	assign q1  = mag_s5[MAG_W-1:15];
	assign r1  = (MAG_W-14)'(mag_s5[14:0]) + (MAG_W-14)'(q1);
	assign q2  = r1[MAG_W-15:15];
	assign r2  = SAMPLE_W'(r1[14:0]) + SAMPLE_W'(q2);
	assign qt  = (MAG_W-13)'(q1) + (MAG_W-13)'(q2) + (MAG_W-13)'(r2 >= SAMPLE_W'(FULL_SCALE));
	assign qs  = (qt > (MAG_W-13)'(FULL_SCALE)) ? AMP_W'(FULL_SCALE) : qt[AMP_W-1:0];
	assign res = neg_s5 ? -{1'b0, qs} : {1'b0, qs};

	// result queue with credits for words in flight
	assign out_valid = (fill_q != '0);
	assign pop       = out_valid && !out_stall;
	assign sample    = fifo_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (v_s5)
			fifo_mem[wr_ptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			credit_q <= '0;
		end else begin
			if (v_s5)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			fill_q   <= fill_q + FIFO_CW'(v_s5) - FIFO_CW'(pop);
			credit_q <= credit_q + FIFO_CW'(accept) - FIFO_CW'(pop);
		end
	end

endmodule
